// ===== hw/rtl/graph_traversal_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// graph_traversal_engine_top_assert
// Assertion macros shared by the graph traversal engine RTL.
// ----------------------------------------------------------------------------
`ifndef GRAPH_TRAVERSAL_ENGINE_TOP_ASSERT_SVH
`define GRAPH_TRAVERSAL_ENGINE_TOP_ASSERT_SVH

// implication checked every clock, quiet during reset
`define GTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gte_pkg.sv =====
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types and constants of the graph traversal engine.
// ----------------------------------------------------------------------------
`default_nettype none
package gte_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 8;
    localparam int VW  = 4;
    localparam int DW  = 3;
    localparam int TD  = MAX_VERTICES * MAX_DEGREE;
    localparam int TAW = 7;

    localparam logic [1:0] ST_VISIT = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD = 2'd3;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_READ,
        S_CHECK,
        S_EMIT
    } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/graph_traversal_engine_top.sv =====
// ----------------------------------------------------------------------------
// graph_traversal_engine_top
// Stores a directed graph as per-vertex neighbour lists and walks it
// depth-first or breadth-first, emitting each reached vertex once.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// request | in        | start & !busy     | action, source_vertex, target_vertex
// result  | out       | result_valid      | status, visited_vertex, last
// config  | in        | cfg_valid&ready   | cfg_index, cfg_data
//
// An add-edge request holds busy while S_EMIT resolves it, and its result is
// registered out of S_EMIT; a bad vertex answers the next cycle, never busy.
// A walk steps through S_READ and then S_CHECK for each stored neighbour
// entry, as the single neighbour-table read port feeds one compare path.
// Each reached vertex is held until the next one is reached so the final one
// can carry last; it leaves as the engine drops busy.
// Reset clears counts, registers and control; the table needs no clear.
// The receiver cannot stall: each result lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_traversal_engine_top_assert.svh"
module graph_traversal_engine_top (
    input  wire  logic                    clk,
    input  wire  logic                    rst_n,
    input  wire  logic                    start,
    output logic                          busy,
    input  wire  logic                    action,
    input  wire  logic [gte_pkg::VW-1:0]  source_vertex,
    input  wire  logic [gte_pkg::VW-1:0]  target_vertex,
    output logic                          result_valid,
    output logic [1:0]                    status,
    output logic [gte_pkg::VW-1:0]        visited_vertex,
    output logic                          last,
    input  wire  logic                    cfg_valid,
    output logic                          cfg_ready,
    input  wire  logic                    cfg_index,
    input  wire  logic [4:0]              cfg_data
);
    import gte_pkg::*;

    // neighbour memory: one write, one registered read
    logic [VW-1:0] table_mem [TD];
    logic [VW-1:0] rd_data_reg;
    logic          tbl_we;
    logic [TAW-1:0] tbl_waddr, tbl_raddr;

    logic [DW:0]   count_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    // walk stack or queue, position per level
    logic [VW-1:0] wv_reg [MAX_VERTICES];
    logic [DW:0]   wp_reg [MAX_VERTICES];

    logic          mode_reg;
    logic [4:0]    vcount_reg;
    state_t        state_reg, state_next;
    logic [VW:0]   head_reg, head_next, tail_reg, tail_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic [DW:0]   pos_reg, pos_next;
    logic [VW-1:0] pend_reg, pend_next;
    // reached vertex waiting for its successor or the end of the walk
    logic          hold_v_reg, hold_v_next;
    logic [VW-1:0] hold_vx_reg, hold_vx_next;

    logic          res_v_next;
    logic [1:0]    res_s_next;
    logic [VW-1:0] res_vx_next;
    logic          res_l_next;

    logic          wv_we, wp_we;
    logic [VW-1:0] wv_addr, wv_data, wp_addr;
    logic [DW:0]   wp_data;
    logic          cnt_inc;
    logic          walk_done;

    logic [4:0]    n_act;
    logic          w_ok;
    logic [DW:0]   cur_cnt;

    assign n_act     = (vcount_reg > 5'(MAX_VERTICES)) ? 5'(MAX_VERTICES) : vcount_reg;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign cur_cnt   = count_reg[cur_reg];
    // neighbour survives if in range and unvisited
    assign w_ok = ({1'b0, rd_data_reg} < n_act) && !vis_reg[rd_data_reg];

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            table_mem[tbl_waddr] <= pend_reg;
        rd_data_reg <= table_mem[tbl_raddr];
        if (wv_we)
            wv_reg[wv_addr] <= wv_data;
        if (wp_we)
            wp_reg[wp_addr] <= wp_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b0;
            vcount_reg   <= 5'd16;
            vis_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            cur_reg      <= '0;
            pos_reg      <= '0;
            pend_reg     <= '0;
            hold_v_reg   <= 1'b0;
            hold_vx_reg  <= '0;
            result_valid <= 1'b0;
            status       <= '0;
            visited_vertex <= '0;
            last         <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            vis_reg      <= vis_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cur_reg      <= cur_next;
            pos_reg      <= pos_next;
            pend_reg     <= pend_next;
            hold_v_reg   <= hold_v_next;
            hold_vx_reg  <= hold_vx_next;
            result_valid <= res_v_next;
            status       <= res_s_next;
            visited_vertex <= res_vx_next;
            last         <= res_l_next;
            if (cnt_inc)
                count_reg[cur_reg] <= cur_cnt + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg   <= cfg_data[0];
                    REG_COUNT: vcount_reg <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        vis_next   = vis_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        hold_v_next  = hold_v_reg;
        hold_vx_next = hold_vx_reg;
        res_v_next = 1'b0;
        res_s_next = ST_VISIT;
        res_vx_next = '0;
        res_l_next = 1'b0;
        tbl_we     = 1'b0;
        tbl_waddr  = {cur_reg, cur_cnt[DW-1:0]};
        tbl_raddr  = {cur_reg, pos_reg[DW-1:0]};
        wv_we = 1'b0; wv_addr = '0; wv_data = '0;
        wp_we = 1'b0; wp_addr = '0; wp_data = '0;
        cnt_inc = 1'b0;
        walk_done = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next  = source_vertex;
                    pend_next = target_vertex;
                    if ({1'b0, source_vertex} >= n_act ||
                        (!action && {1'b0, target_vertex} >= n_act))
                    begin
                        res_v_next = 1'b1;
                        res_s_next = ST_BAD;
                        res_l_next = 1'b1;
                    end
                    else if (!action)
                        state_next = S_EMIT;   // add edge: resolve next cycle
                    else
                    begin
                        // seed the walk; hold the start vertex now in DFS
                        vis_next = '0;
                        vis_next[source_vertex] = 1'b1;
                        wv_we = 1'b1; wv_addr = '0; wv_data = source_vertex;
                        wp_we = 1'b1; wp_addr = '0; wp_data = '0;
                        head_next = mode_reg ? 5'd0 : 5'd1;
                        tail_next = 5'd1;
                        if (!mode_reg)
                        begin
                            hold_v_next  = 1'b1;
                            hold_vx_next = source_vertex;
                        end
                        state_next = S_POP;
                    end
                end
            end
            S_EMIT:
            begin
                // add-edge completion
                res_v_next = 1'b1;
                res_l_next = 1'b1;
                if (cur_cnt >= (DW+1)'(MAX_DEGREE))
                    res_s_next = ST_FULL;
                else
                begin
                    tbl_we  = 1'b1;
                    cnt_inc = 1'b1;
                    res_s_next = ST_STORED;
                end
                state_next = S_IDLE;
            end
            S_POP:
            begin
                if (mode_reg)
                begin
                    // dequeue; release the previous vertex and hold this one
                    cur_next     = wv_reg[head_reg[VW-1:0]];
                    head_next    = head_reg + 1'b1;
                    pos_next     = '0;
                    res_v_next   = hold_v_reg;
                    res_vx_next  = hold_vx_reg;
                    hold_v_next  = 1'b1;
                    hold_vx_next = wv_reg[head_reg[VW-1:0]];
                    state_next   = S_READ;
                end
                else if (head_reg == '0)
                begin
                    walk_done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = wv_reg[head_reg[VW-1:0] - 1'b1];
                    pos_next   = wp_reg[head_reg[VW-1:0] - 1'b1];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (pos_reg < cur_cnt && pos_reg < (DW+1)'(MAX_DEGREE))
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_CHECK;
                end
                else if (mode_reg)
                begin
                    walk_done  = (head_reg == tail_reg);
                    state_next = (head_reg == tail_reg) ? S_IDLE : S_POP;
                end
                else
                begin
                    head_next  = head_reg - 1'b1;
                    walk_done  = (head_reg == 5'd1);
                    state_next = (head_reg == 5'd1) ? S_IDLE : S_POP;
                end
            end
            S_CHECK:
            begin
                state_next = S_READ;
                if (w_ok && mode_reg)
                begin
                    vis_next[rd_data_reg] = 1'b1;
                    wv_we = 1'b1; wv_addr = tail_reg[VW-1:0]; wv_data = rd_data_reg;
                    tail_next = tail_reg + 1'b1;
                end
                else if (w_ok)
                begin
                    // save the parent's scan position, push and descend
                    vis_next[rd_data_reg] = 1'b1;
                    wp_we = 1'b1; wp_addr = head_reg[VW-1:0] - 1'b1; wp_data = pos_reg;
                    wv_we = 1'b1; wv_addr = head_reg[VW-1:0]; wv_data = rd_data_reg;
                    head_next    = head_reg + 1'b1;
                    res_v_next   = hold_v_reg;
                    res_vx_next  = hold_vx_reg;
                    hold_v_next  = 1'b1;
                    hold_vx_next = rd_data_reg;
                    cur_next     = rd_data_reg;
                    pos_next     = '0;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // end of walk: release the held vertex as the final result
        if (walk_done)
        begin
            res_v_next  = 1'b1;
            res_vx_next = hold_vx_reg;
            res_l_next  = 1'b1;
            hold_v_next = 1'b0;
        end
    end

    `GTE_ASSERT_IMP(a_last_has_strobe, last, result_valid, "last raised without a result")
    `GTE_ASSERT_IMP(a_edge_result_final, result_valid && (status != ST_VISIT), last, "edge or bad result not final")
    `GTE_ASSERT_IMP(a_edge_result_no_vertex, result_valid && (status != ST_VISIT), visited_vertex == '0, "vertex set on non-visit result")
    `GTE_ASSERT_NXT(a_walk_goes_busy, start && !busy && action && (5'(source_vertex) < n_act), busy, "valid walk request did not raise busy")

endmodule
`default_nettype wire
